// ----- rtl/core/ncb_pkg.sv -----
// Package for the nearest cell boundary level map.
// Holds the sizing constants, the request kinds, the controller states and the token type
// that travels along the level chain. No dependencies.
package ncb_pkg;

    localparam int MAX_CELLS  = 256;
    localparam int COORD_BITS = 32;

    localparam int CELL_IDX_W = $clog2(MAX_CELLS);
    localparam int CELL_CNT_W = CELL_IDX_W + 1;
    localparam int TOP_W      = COORD_BITS - 1;

    localparam int CFG_CNT_W  = 9;
    localparam int CNT_CMP_W  = (CELL_CNT_W > CFG_CNT_W) ? CELL_CNT_W : CFG_CNT_W;
    localparam int BND_W      = 8;
    localparam int LVL_W      = 8;
    localparam int TOTAL_W    = 9;

    localparam int CFG_ADDR_W = 3;
    localparam logic [0:0] REG_CELL_COUNT = 1'b0;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } ncb_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_PICK,
        ST_LEVEL,
        ST_DONE
    } ncb_state_t;

    typedef struct packed {
        logic                  valid;
        logic [CELL_IDX_W-1:0] key;
        logic                  hit;
        logic                  fresh;
        logic [CELL_IDX_W-1:0] level;
    } ncb_token_t;

endpackage

// ----- rtl/core/ncb_level_cell.sv -----
// One cell of the level chain: holds one entry of the level list and passes the search
// token on to its neighbour every cycle. Depends on ncb_pkg.
module ncb_level_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ncb_pkg::CELL_IDX_W-1:0] cell_id,
    input  logic [ncb_pkg::CELL_CNT_W-1:0] level_total,
    input  ncb_pkg::ncb_token_t           token_in,
    output ncb_pkg::ncb_token_t           token_out
);
    import ncb_pkg::*;

    logic [CELL_IDX_W-1:0] entry_reg, entry_next;
    ncb_token_t            token_reg, token_next;
    logic                  live, match, claim;

    always_comb begin
        live       = {1'b0, cell_id} < level_total;
        match      = token_in.valid && !token_in.hit && live && (entry_reg == token_in.key);
        claim      = token_in.valid && !token_in.hit && ({1'b0, cell_id} == level_total);
        token_next = token_in;
        entry_next = entry_reg;
        if (match) begin
            token_next.hit   = 1'b1;
            token_next.level = cell_id;
        end else if (claim) begin
            token_next.hit   = 1'b1;
            token_next.fresh = 1'b1;
            token_next.level = cell_id;
            entry_next       = token_in.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg <= '0;
        end else begin
            token_reg <= token_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign token_out = token_reg;

endmodule

// ----- rtl/core/ncb_level_chain.sv -----
// The row of level cells, one per possible level, linked head to tail.
// Depends on ncb_pkg and ncb_level_cell.
module ncb_level_chain (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ncb_pkg::CELL_CNT_W-1:0] level_total,
    input  ncb_pkg::ncb_token_t           token_in,
    output ncb_pkg::ncb_token_t           token_out
);
    import ncb_pkg::*;

    ncb_token_t link [0:MAX_CELLS];

    assign link[0] = token_in;

    for (genvar g = 0; g < MAX_CELLS; g++) begin : g_cell
        ncb_level_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_id     (CELL_IDX_W'(g)),
            .level_total (level_total),
            .token_in    (link[g]),
            .token_out   (link[g+1])
        );
    end

    assign token_out = link[MAX_CELLS];

endmodule

// ----- rtl/core/nearest_cell_boundary_level_map_core.sv -----
// Top level of the nearest cell boundary level map: configuration port, cell tables,
// search controller and output register. Depends on ncb_pkg and ncb_level_chain.
// Loads write the cell tables when taken and clears reset the level count. A query passes
// through ST_CHECK and, when in domain, ST_SCAN, ST_PICK and ST_LEVEL, then ST_DONE.
// One query at a time; the next request is taken once the controller is back in ST_IDLE,
// later while an earlier result still waits on m_tready.
// Reset: controller, output valid, level count and cell count (to 1) clear; the tables and
// the level list are not cleared and take no clearing pass.
module nearest_cell_boundary_level_map_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: cell_index[7:0], cell_top[38:8], cell_thickness[69:39], query_depth[101:70]
    input  logic [103:0]                      s_tdata,
    // s_tuser: kind[1:0]
    input  logic [1:0]                        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: boundary_index[7:0], level_index[15:8], new_level[16], shift_depth[47:17],
    // levels_so_far[56:48]
    output logic [63:0]                       m_tdata,
    // m_tuser: out_of_domain[0]
    output logic [0:0]                        m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ncb_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import ncb_pkg::*;

    ncb_state_t            state_reg, state_next;
    logic [CFG_CNT_W-1:0]  cell_count_reg, cell_count_next;
    logic [CELL_CNT_W-1:0] level_total_reg, level_total_next;
    logic [COORD_BITS-1:0] depth_reg, depth_next;
    logic [CELL_IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [CELL_IDX_W-1:0] pick_reg, pick_next;
    logic [TOP_W-1:0]      shift_reg, shift_next;

    logic [CELL_IDX_W-1:0] res_bnd_reg, res_bnd_next;
    logic [CELL_IDX_W-1:0] res_lvl_reg, res_lvl_next;
    logic                  res_fresh_reg, res_fresh_next;
    logic [TOP_W-1:0]      res_shift_reg, res_shift_next;
    logic [CELL_CNT_W-1:0] res_total_reg, res_total_next;
    logic                  res_ood_reg, res_ood_next;

    logic                  out_valid_reg, out_valid_next;
    logic [BND_W-1:0]      out_bnd_reg, out_bnd_next;
    logic [LVL_W-1:0]      out_lvl_reg, out_lvl_next;
    logic                  out_fresh_reg, out_fresh_next;
    logic [TOP_W-1:0]      out_shift_reg, out_shift_next;
    logic [TOTAL_W-1:0]    out_total_reg, out_total_next;
    logic                  out_ood_reg, out_ood_next;

    logic [TOP_W-1:0]      top_mem [0:MAX_CELLS-1];
    logic [TOP_W-1:0]      thk_mem [0:MAX_CELLS-1];
    logic [TOP_W-1:0]      rd_top_reg, rd_thk_reg;
    logic [CELL_IDX_W-1:0] rd_addr;

    logic [CNT_CMP_W-1:0]  cnt_ext;
    logic [CELL_IDX_W-1:0] last_idx;
    logic                  accept, cfg_write, load_we, inject;
    logic [1:0]            kind;
    logic [TOP_W-1:0]      depth_pos;
    logic [COORD_BITS-1:0] bottom;
    logic [COORD_BITS:0]   twice_sum, twice_depth;
    logic                  beyond, near_top, scan_more, out_of_range;
    logic [CELL_IDX_W-1:0] pick_sel;
    ncb_token_t            chain_in, chain_out;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cell_count_next = cell_count_reg;
        if (cfg_write && (paddr[CFG_ADDR_W-1:2] == REG_CELL_COUNT)) begin
            cell_count_next = pwdata[CFG_CNT_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[CFG_ADDR_W-1:2])
            REG_CELL_COUNT: prdata = 32'(cell_count_reg);
            default:        prdata = 32'd0;
        endcase
    end

    always_comb begin
        cnt_ext = CNT_CMP_W'(cell_count_reg);
        if (cnt_ext > CNT_CMP_W'(MAX_CELLS)) begin
            last_idx = CELL_IDX_W'(MAX_CELLS - 1);
        end else if (cnt_ext == '0) begin
            last_idx = '0;
        end else begin
            last_idx = CELL_IDX_W'(cnt_ext - 1'b1);
        end
    end

    // Input side.
    assign kind    = s_tuser;
    assign accept  = s_tvalid && s_tready;
    assign load_we = accept && (kind == KIND_LOAD)
                     && (32'(s_tdata[7:0]) < 32'(MAX_CELLS));

    // Search arithmetic on the registered table read.
    always_comb begin
        depth_pos    = depth_reg[TOP_W-1:0];
        bottom       = {1'b0, rd_top_reg} + {1'b0, rd_thk_reg};
        twice_sum    = {1'b0, rd_top_reg, 1'b0} + {2'b00, rd_thk_reg};
        twice_depth  = {1'b0, depth_pos, 1'b0};
        beyond       = {1'b0, depth_pos} > bottom;
        near_top     = twice_depth < twice_sum;
        out_of_range = depth_reg[COORD_BITS-1] || beyond;
        scan_more    = (scan_idx_reg < last_idx) && beyond;
        if (near_top) begin
            pick_sel = scan_idx_reg;
        end else if (scan_idx_reg < last_idx) begin
            pick_sel = scan_idx_reg + 1'b1;
        end else begin
            pick_sel = last_idx;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (kind == KIND_QUERY)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = out_of_range ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                if (!scan_more) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                state_next = ST_LEVEL;
            end
            ST_LEVEL: begin
                if (chain_out.valid) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        s_tready = 1'b0;
        inject   = 1'b0;
        rd_addr  = pick_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                rd_addr  = last_idx;
            end
            ST_CHECK: rd_addr = '0;
            ST_SCAN:  rd_addr = scan_more ? scan_idx_reg + 1'b1 : pick_sel;
            ST_PICK:  inject  = 1'b1;
            ST_LEVEL: rd_addr = pick_reg;
            ST_DONE:  rd_addr = pick_reg;
            default:  rd_addr = pick_reg;
        endcase
    end

    // Datapath.
    always_comb begin
        level_total_next = level_total_reg;
        depth_next       = depth_reg;
        scan_idx_next    = scan_idx_reg;
        pick_next        = pick_reg;
        shift_next       = shift_reg;
        res_bnd_next     = res_bnd_reg;
        res_lvl_next     = res_lvl_reg;
        res_fresh_next   = res_fresh_reg;
        res_shift_next   = res_shift_reg;
        res_total_next   = res_total_reg;
        res_ood_next     = res_ood_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_bnd_next     = out_bnd_reg;
        out_lvl_next     = out_lvl_reg;
        out_fresh_next   = out_fresh_reg;
        out_shift_next   = out_shift_reg;
        out_total_next   = out_total_reg;
        out_ood_next     = out_ood_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept && (kind == KIND_QUERY)) begin
                    depth_next = s_tdata[101:70];
                end
                if (accept && (kind == KIND_CLEAR)) begin
                    level_total_next = '0;
                end
            end
            ST_CHECK: begin
                scan_idx_next = '0;
                if (out_of_range) begin
                    res_bnd_next   = '0;
                    res_lvl_next   = '0;
                    res_fresh_next = 1'b0;
                    res_shift_next = '0;
                    res_total_next = level_total_reg;
                    res_ood_next   = 1'b1;
                end
            end
            ST_SCAN: begin
                if (scan_more) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end else begin
                    pick_next = pick_sel;
                end
            end
            ST_PICK: begin
                shift_next = rd_top_reg;
            end
            ST_LEVEL: begin
                if (chain_out.valid) begin
                    level_total_next = level_total_reg + CELL_CNT_W'(chain_out.fresh);
                    res_bnd_next     = pick_reg;
                    res_lvl_next     = chain_out.level;
                    res_fresh_next   = chain_out.fresh;
                    res_shift_next   = shift_reg;
                    res_total_next   = level_total_reg + CELL_CNT_W'(chain_out.fresh);
                    res_ood_next     = 1'b0;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_bnd_next   = BND_W'(res_bnd_reg);
                    out_lvl_next   = LVL_W'(res_lvl_reg);
                    out_fresh_next = res_fresh_reg;
                    out_shift_next = res_shift_reg;
                    out_total_next = TOTAL_W'(res_total_reg);
                    out_ood_next   = res_ood_reg;
                end
            end
            default: begin
                depth_next = depth_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cell_count_reg  <= CFG_CNT_W'(1);
            level_total_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cell_count_reg  <= cell_count_next;
            level_total_reg <= level_total_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        depth_reg     <= depth_next;
        scan_idx_reg  <= scan_idx_next;
        pick_reg      <= pick_next;
        shift_reg     <= shift_next;
        res_bnd_reg   <= res_bnd_next;
        res_lvl_reg   <= res_lvl_next;
        res_fresh_reg <= res_fresh_next;
        res_shift_reg <= res_shift_next;
        res_total_reg <= res_total_next;
        res_ood_reg   <= res_ood_next;
        out_bnd_reg   <= out_bnd_next;
        out_lvl_reg   <= out_lvl_next;
        out_fresh_reg <= out_fresh_next;
        out_shift_reg <= out_shift_next;
        out_total_reg <= out_total_next;
        out_ood_reg   <= out_ood_next;
    end

    // Cell tables.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            top_mem[CELL_IDX_W'(s_tdata[7:0])] <= s_tdata[38:8];
            thk_mem[CELL_IDX_W'(s_tdata[7:0])] <= s_tdata[69:39];
        end
        rd_top_reg <= top_mem[rd_addr];
        rd_thk_reg <= thk_mem[rd_addr];
    end

    // Level list search.
    always_comb begin
        chain_in       = '0;
        chain_in.valid = inject;
        chain_in.key   = pick_reg;
    end

    ncb_level_chain u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .level_total (level_total_reg),
        .token_in    (chain_in),
        .token_out   (chain_out)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ood_reg;
    assign m_tdata  = {7'd0, out_total_reg, out_shift_reg, out_fresh_reg, out_lvl_reg,
                       out_bnd_reg};

    a_chain_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        inject |-> ##(MAX_CELLS) chain_out.valid)
        else $error("Search token did not leave the level chain on time.");

    a_chain_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_out.valid |-> (state_reg == ST_LEVEL))
        else $error("Level chain produced a token while no query was waiting for it.");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_total_reg <= CELL_CNT_W'(MAX_CELLS))
        else $error("Level count exceeds the number of level cells.");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_idx_reg <= last_idx))
        else $error("Table scan ran past the last cell in use.");

endmodule
